// ===== rtl/prpwm_pkg.sv =====
// ----------------------------------------------------------------------------
// prpwm_pkg
// shared types, constants and helpers of the packed-register four-channel pwm
// ----------------------------------------------------------------------------
`default_nettype none

package prpwm_pkg;

  localparam int unsigned LanesMax = 4;
  localparam int unsigned ChannelsDefault = 4;

  localparam int unsigned WordW = 32;
  localparam int unsigned OcdW = 8;
  localparam int unsigned CdW = 8;
  localparam int unsigned CsdW = 4;
  localparam int unsigned SrcWordW = 16;
  localparam int unsigned PrescaleW = 16;
  localparam int unsigned PeriodW = 8;

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_WRITE = 2'd1,
    OP_READ  = 2'd2
  } op_e;

  localparam logic [1:0] ADDR_OUT_DIV = 2'd0;
  localparam logic [1:0] ADDR_DUTY    = 2'd1;
  localparam logic [1:0] ADDR_SRC_DIV = 2'd2;

  typedef struct packed {
    op_e              op;
    logic [1:0]       addr;
    logic [WordW-1:0] wdata;
  } in_beat_t;

  typedef struct packed {
    logic [WordW-1:0]    rdata;
    logic [LanesMax-1:0] pwm_level;
    logic [LanesMax-1:0] channel_enabled;
  } out_beat_t;

  typedef struct packed {
    logic tick;
    logic clear;
  } lane_ctl_t;

  typedef struct packed {
    logic level;
    logic enabled;
  } lane_stat_t;

  // terminal prescale count: 2^(csd+1) - 1
  function automatic logic [PrescaleW-1:0] src_last(input logic [CsdW-1:0] csd);
    logic [CsdW-1:0] sh;
    sh = 4'd15 - csd;
    return {PrescaleW{1'b1}} >> sh;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/packed_register_pwm_four_channel_top.sv =====
// ----------------------------------------------------------------------------
// packed_register_pwm_four_channel_top
// four-channel pwm with clock prescaler behind three packed registers
// ----------------------------------------------------------------------------
// Each input beat is one source-clock tick, one register write or one register
// read (any other op changes nothing), and each gives exactly one output beat
// showing the state after it. The block takes one beat per cycle while the output
// is not stalled; a beat is held in the input register, then executed into the
// result register (the register update, lane counters and result register all
// move on the same edge). Back-pressure on the output stalls the input register,
// and in_ready_o follows out_ready_i combinationally so no bubble is added.
// Channels whose ocd, cd and csd fields are all zero are disabled and held low;
// any write clears every counter.
`default_nettype none

module packed_register_pwm_four_channel_top #(
  parameter int unsigned CHANNELS = prpwm_pkg::ChannelsDefault
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire prpwm_pkg::in_beat_t  in_data_i,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output prpwm_pkg::out_beat_t      out_data_o
);

  // input register
  logic                 in_valid_q;
  prpwm_pkg::in_beat_t  in_q;

  // result register
  logic                 out_valid_q;
  prpwm_pkg::out_beat_t out_q, out_d;

  logic advance;   // result register free this cycle
  logic proc;      // held beat is executed this cycle
  logic in_fire;

  assign advance    = !out_valid_q || out_ready_i;
  assign proc       = in_valid_q && advance;
  assign in_ready_o = advance || !in_valid_q;
  assign in_fire    = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_fire) begin
      in_valid_q <= 1'b1;
    end else if (proc) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      in_q <= in_data_i;
    end
  end

  // register file: next-state words feed the lanes so results show post-beat state
  logic [prpwm_pkg::WordW-1:0]    out_div_d;
  logic [prpwm_pkg::WordW-1:0]    duty_d;
  logic [prpwm_pkg::SrcWordW-1:0] src_div_d;
  logic [prpwm_pkg::WordW-1:0]    rdata;

  prpwm_regs u_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .proc_i      (proc),
    .beat_i      (in_q),
    .out_div_d_o (out_div_d),
    .duty_d_o    (duty_d),
    .src_div_d_o (src_div_d),
    .rdata_o     (rdata)
  );

  // lane control: ticks advance counters, writes clear them
  prpwm_pkg::lane_ctl_t lane_ctl;
  assign lane_ctl.tick  = proc && (in_q.op == prpwm_pkg::OP_TICK);
  assign lane_ctl.clear = proc && (in_q.op == prpwm_pkg::OP_WRITE);

  logic [prpwm_pkg::LanesMax-1:0] level;
  logic [prpwm_pkg::LanesMax-1:0] enabled;

  for (genvar n = 0; n < prpwm_pkg::LanesMax; n++) begin : g_lane
    if (n < CHANNELS) begin : g_on
      prpwm_pkg::lane_stat_t stat;
      prpwm_lane u_lane (
        .clk_i  (clk_i),
        .rst_ni (rst_ni),
        .ctl_i  (lane_ctl),
        .ocd_i  (out_div_d[prpwm_pkg::OcdW*n +: prpwm_pkg::OcdW]),
        .cd_i   (duty_d[prpwm_pkg::CdW*n +: prpwm_pkg::CdW]),
        .csd_i  (src_div_d[prpwm_pkg::CsdW*n +: prpwm_pkg::CsdW]),
        .stat_o (stat)
      );
      assign level[n]   = stat.level;
      assign enabled[n] = stat.enabled;
    end else begin : g_off
      // channel not built: never counts, reads low and disabled
      assign level[n]   = 1'b0;
      assign enabled[n] = 1'b0;
    end
  end

  assign out_d.rdata           = rdata;
  assign out_d.pwm_level       = level;
  assign out_d.channel_enabled = enabled;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (proc) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (proc) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // a channel is never high while disabled
  a_level_enabled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((out_data_o.pwm_level & ~out_data_o.channel_enabled) == '0))
    else $error("level high on disabled channel");

  // channels that are not built stay quiet
  a_unbuilt_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((out_data_o.channel_enabled >> CHANNELS) == '0))
    else $error("unbuilt channel reported enabled");

  // with the result register empty, a new beat is always taken
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_q |-> in_ready_o)
    else $error("input stalled with empty result register");

  // a held beat is executed whenever the output moves
  a_no_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && out_ready_i) |=> out_valid_q)
    else $error("held beat not executed");

endmodule

`default_nettype wire

// ===== rtl/prpwm_regs.sv =====
// ----------------------------------------------------------------------------
// prpwm_regs
// packed divider and duty words with write decode and read mux
// ----------------------------------------------------------------------------
`default_nettype none

module prpwm_regs (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              proc_i,
  input  wire prpwm_pkg::in_beat_t               beat_i,
  output logic [prpwm_pkg::WordW-1:0]            out_div_d_o,
  output logic [prpwm_pkg::WordW-1:0]            duty_d_o,
  output logic [prpwm_pkg::SrcWordW-1:0]         src_div_d_o,
  output logic [prpwm_pkg::WordW-1:0]            rdata_o
);

  logic [prpwm_pkg::WordW-1:0]    out_div_q, out_div_d;
  logic [prpwm_pkg::WordW-1:0]    duty_q, duty_d;
  logic [prpwm_pkg::SrcWordW-1:0] src_div_q, src_div_d;

  always_comb begin
    out_div_d = out_div_q;
    duty_d    = duty_q;
    src_div_d = src_div_q;
    rdata_o   = '0;
    if (proc_i) begin
      case (beat_i.op)
        prpwm_pkg::OP_WRITE: begin
          case (beat_i.addr)
            prpwm_pkg::ADDR_OUT_DIV: out_div_d = beat_i.wdata;
            prpwm_pkg::ADDR_DUTY:    duty_d = beat_i.wdata;
            prpwm_pkg::ADDR_SRC_DIV: src_div_d = beat_i.wdata[prpwm_pkg::SrcWordW-1:0];
            default: ;
          endcase
        end
        prpwm_pkg::OP_READ: begin
          case (beat_i.addr)
            prpwm_pkg::ADDR_OUT_DIV: rdata_o = out_div_q;
            prpwm_pkg::ADDR_DUTY:    rdata_o = duty_q;
            // upper half reads as zero
            prpwm_pkg::ADDR_SRC_DIV: rdata_o = {{(prpwm_pkg::WordW-prpwm_pkg::SrcWordW){1'b0}},
                                                src_div_q};
            default: ;
          endcase
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_div_q <= '0;
      duty_q    <= '0;
      src_div_q <= '0;
    end else begin
      out_div_q <= out_div_d;
      duty_q    <= duty_d;
      src_div_q <= src_div_d;
    end
  end

  assign out_div_d_o = out_div_d;
  assign duty_d_o    = duty_d;
  assign src_div_d_o = src_div_d;

endmodule

`default_nettype wire

// ===== rtl/prpwm_lane.sv =====
// ----------------------------------------------------------------------------
// prpwm_lane
// one pwm channel: prescale counter, period counter and output compare
// ----------------------------------------------------------------------------
`default_nettype none

module prpwm_lane (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire prpwm_pkg::lane_ctl_t          ctl_i,
  input  wire logic [prpwm_pkg::OcdW-1:0]    ocd_i,
  input  wire logic [prpwm_pkg::CdW-1:0]     cd_i,
  input  wire logic [prpwm_pkg::CsdW-1:0]    csd_i,
  output prpwm_pkg::lane_stat_t              stat_o
);

  logic [prpwm_pkg::PrescaleW-1:0] prescale_q, prescale_d;
  logic [prpwm_pkg::PeriodW-1:0]   period_q, period_d;
  logic [prpwm_pkg::PrescaleW-1:0] last;
  logic                            enabled;

  assign enabled = (ocd_i != '0) || (cd_i != '0) || (csd_i != '0);
  assign last    = prpwm_pkg::src_last(csd_i);

  always_comb begin
    prescale_d = prescale_q;
    period_d   = period_q;
    if (ctl_i.clear) begin
      prescale_d = '0;
      period_d   = '0;
    end else if (ctl_i.tick) begin
      if (!enabled) begin
        prescale_d = '0;
        period_d   = '0;
      end else if (prescale_q >= last) begin
        prescale_d = '0;
        period_d   = (period_q >= ocd_i) ? '0 : period_q + 8'd1;
      end else begin
        prescale_d = prescale_q + 16'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prescale_q <= '0;
      period_q   <= '0;
    end else begin
      prescale_q <= prescale_d;
      period_q   <= period_d;
    end
  end

  assign stat_o.enabled = enabled;
  assign stat_o.level   = enabled && (period_d <= cd_i);

  // a write leaves both counters at zero
  a_clear_zeroes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.clear |=> (prescale_q == '0) && (period_q == '0))
    else $error("counters not cleared after write");

  // a tick on a disabled channel holds its counters at zero
  a_disabled_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctl_i.tick && !enabled) |=> (prescale_q == '0) && (period_q == '0))
    else $error("disabled channel counted");

  // the prescaler only ever moves by one or wraps to zero
  a_prescale_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.tick |=> (prescale_q == '0) || (prescale_q == $past(prescale_q) + 16'd1))
    else $error("prescaler jumped");

endmodule

`default_nettype wire

// ===== bench/packed_register_pwm_four_channel_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// packed_register_pwm_four_channel_top_tb
// self-checking bench for the packed-register four-channel pwm
// ----------------------------------------------------------------------------
// A queue of ticks, register writes and reads is filled up front: a short
// directed opening, then random register programs each followed by a run of
// ticks with reads and stray writes mixed in. A clocked driver sends the queue
// in random bursts, a clocked monitor stalls the output on its own pattern.
// Every accepted beat is run through a behavioral pwm model kept in this file,
// and every output beat is checked field by field against the oldest
// prediction.

module packed_register_pwm_four_channel_top_tb;

  localparam int unsigned Lanes = prpwm_pkg::ChannelsDefault;
  localparam logic [1:0] OpUnknown = 2'd3;   // not an op_e member, block ignores it
  localparam logic [1:0] AddrUnused = 2'd3;
  localparam int unsigned RandomBeats = 1450;
  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned DrainCycles = 20;  // result passes the input and result registers after accept

  // one queued input beat; hold makes the driver wait until all results are in
  typedef struct {
    prpwm_pkg::in_beat_t beat;
    bit                  hold;
  } pending_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 in_valid_i = 1'b0;
  logic                 in_ready_o;
  prpwm_pkg::in_beat_t  in_data_i = '0;
  logic                 out_valid_o;
  logic                 out_ready_i = 1'b0;
  prpwm_pkg::out_beat_t out_data_o;

  packed_register_pwm_four_channel_top #(
    .CHANNELS(Lanes)
  ) uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  // --------------------------------------------------------------------------
  // pwm model state: the three packed registers and the per-lane counters
  // --------------------------------------------------------------------------
  logic [prpwm_pkg::WordW-1:0]     ocd_word = '0;
  logic [prpwm_pkg::WordW-1:0]     duty_word = '0;
  logic [prpwm_pkg::SrcWordW-1:0]  csd_word = '0;
  logic [prpwm_pkg::PrescaleW-1:0] prescale_q [prpwm_pkg::LanesMax];
  logic [prpwm_pkg::PeriodW-1:0]   period_q [prpwm_pkg::LanesMax];

  pending_t             pending_q [$];
  prpwm_pkg::out_beat_t expected_q [$];

  int unsigned n_accepted = 0;  // driver side only
  int unsigned n_checked = 0;   // monitor side only, updated nonblocking
  int unsigned mismatches = 0;
  int unsigned cycle_count = 0;

  initial begin
    for (int n = 0; n < prpwm_pkg::LanesMax; n++) begin
      prescale_q[n] = '0;
      period_q[n] = '0;
    end
  end

  // advance the model by one beat and return the output beat it should give
  function automatic prpwm_pkg::out_beat_t pwm_step(input prpwm_pkg::in_beat_t b);
    prpwm_pkg::out_beat_t       r;
    logic [prpwm_pkg::OcdW-1:0] ocd;
    logic [prpwm_pkg::CdW-1:0]  cd;
    logic [prpwm_pkg::CsdW-1:0] csd;
    int unsigned                last;
    r = '0;
    case (b.op)
      prpwm_pkg::OP_TICK: begin
        for (int n = 0; n < Lanes; n++) begin
          ocd = ocd_word[prpwm_pkg::OcdW*n +: prpwm_pkg::OcdW];
          cd = duty_word[prpwm_pkg::CdW*n +: prpwm_pkg::CdW];
          csd = csd_word[prpwm_pkg::CsdW*n +: prpwm_pkg::CsdW];
          if ({ocd, cd, csd} == '0) begin
            // disabled lane keeps its counters parked at zero
            prescale_q[n] = '0;
            period_q[n] = '0;
          end else begin
            last = (32'd1 << (int'(csd) + 1)) - 1;
            if (int'(prescale_q[n]) >= last) begin
              prescale_q[n] = '0;
              if (period_q[n] >= ocd) begin
                period_q[n] = '0;
              end else begin
                period_q[n] = period_q[n] + 1'b1;
              end
            end else begin
              prescale_q[n] = prescale_q[n] + 1'b1;
            end
          end
        end
      end
      prpwm_pkg::OP_WRITE: begin
        case (b.addr)
          prpwm_pkg::ADDR_OUT_DIV: ocd_word = b.wdata;
          prpwm_pkg::ADDR_DUTY:    duty_word = b.wdata;
          prpwm_pkg::ADDR_SRC_DIV: csd_word = b.wdata[prpwm_pkg::SrcWordW-1:0];
          default: ;
        endcase
        // any write, even to the unused word, restarts every lane
        for (int n = 0; n < prpwm_pkg::LanesMax; n++) begin
          prescale_q[n] = '0;
          period_q[n] = '0;
        end
      end
      prpwm_pkg::OP_READ: begin
        case (b.addr)
          prpwm_pkg::ADDR_OUT_DIV: r.rdata = ocd_word;
          prpwm_pkg::ADDR_DUTY:    r.rdata = duty_word;
          prpwm_pkg::ADDR_SRC_DIV: r.rdata = {{(prpwm_pkg::WordW-prpwm_pkg::SrcWordW){1'b0}},
                                              csd_word};
          default:                 r.rdata = '0;
        endcase
      end
      default: ;
    endcase
    for (int n = 0; n < Lanes; n++) begin
      ocd = ocd_word[prpwm_pkg::OcdW*n +: prpwm_pkg::OcdW];
      cd = duty_word[prpwm_pkg::CdW*n +: prpwm_pkg::CdW];
      csd = csd_word[prpwm_pkg::CsdW*n +: prpwm_pkg::CsdW];
      if ({ocd, cd, csd} != '0) begin
        r.channel_enabled[n] = 1'b1;
        r.pwm_level[n] = (period_q[n] <= cd);
      end
    end
    return r;
  endfunction

  task automatic enqueue(input logic [1:0] op, input logic [1:0] addr,
                         input logic [prpwm_pkg::WordW-1:0] data, input bit hold);
    pending_t p;
    p.beat.op = prpwm_pkg::op_e'(op);
    p.beat.addr = addr;
    p.beat.wdata = data;
    p.hold = hold;
    pending_q.push_back(p);
  endtask

  // packed per-lane fields, each lane left unset a quarter of the time
  function automatic logic [prpwm_pkg::WordW-1:0] lane_fields(input int unsigned lane_w,
                                                              input int unsigned maxv);
    logic [prpwm_pkg::WordW-1:0] w;
    logic [prpwm_pkg::WordW-1:0] v;
    w = '0;
    for (int n = 0; n < prpwm_pkg::LanesMax; n++) begin
      if ($urandom_range(0, 3) != 0) begin
        v = $urandom_range(0, maxv);
        w |= v << (lane_w * n);
      end
    end
    return w;
  endfunction

  // --------------------------------------------------------------------------
  // clock, reset and timeout
  // --------------------------------------------------------------------------
  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  always @(posedge clk_i) begin : watchdog
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("packed_register_pwm_four_channel_top regression: fail");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // driver: bursts of beats from pending_q with random gaps in between
  // --------------------------------------------------------------------------
  int unsigned burst_left = 0;
  int unsigned gap_left = 0;

  always @(posedge clk_i) begin : driver
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        // predict at acceptance so the model sees beats in block order
        expected_q.push_back(pwm_step(in_data_i));
        void'(pending_q.pop_front());
        n_accepted++;
      end
      // payload may only change once the current beat is gone
      if (!in_valid_i || in_ready_o) begin
        if (gap_left != 0) begin
          gap_left--;
          in_valid_i <= 1'b0;
        end else if (pending_q.size() != 0 &&
                     !(pending_q[0].hold && n_accepted != n_checked)) begin
          in_valid_i <= 1'b1;
          in_data_i <= pending_q[0].beat;
          if (burst_left != 0) begin
            burst_left--;
          end else begin
            // mostly short bursts, now and then a long back-to-back stretch
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(50, 200)
                                                     : $urandom_range(1, 12);
            gap_left = $urandom_range(1, 6);
          end
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // monitor: checks each output beat and drives the ready stall pattern
  // --------------------------------------------------------------------------
  logic [31:0] stall_pat = '1;
  logic [6:0]  stall_win = '0;

  always @(posedge clk_i) begin : monitor
    prpwm_pkg::out_beat_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_q.size() == 0) begin
        $error("output beat with nothing expected: %h", out_data_o);
        mismatches++;
      end else begin
        want = expected_q.pop_front();
        if (out_data_o.rdata !== want.rdata) begin
          $error("rdata: expected %h, got %h", want.rdata, out_data_o.rdata);
          mismatches++;
        end
        if (out_data_o.pwm_level !== want.pwm_level) begin
          $error("pwm_level: expected %b, got %b", want.pwm_level,
                 out_data_o.pwm_level);
          mismatches++;
        end
        if (out_data_o.channel_enabled !== want.channel_enabled) begin
          $error("channel_enabled: expected %b, got %b", want.channel_enabled,
                 out_data_o.channel_enabled);
          mismatches++;
        end
      end
      n_checked <= n_checked + 1;
    end
    // new stall pattern each time stall_win runs down: always ready, even, sparse or dense stalls
    if (stall_win == 0) begin
      stall_win <= 7'd63;
      case ($urandom_range(0, 3))
        0:       stall_pat <= '1;
        1:       stall_pat <= $urandom;
        2:       stall_pat <= $urandom | $urandom;
        default: stall_pat <= $urandom & $urandom;
      endcase
    end else begin
      stall_win <= stall_win - 1'b1;
    end
    out_ready_i <= stall_pat[stall_win[4:0]];
  end

  // --------------------------------------------------------------------------
  // stimulus and end of run
  // --------------------------------------------------------------------------
  initial begin : stimulus
    logic [prpwm_pkg::WordW-1:0] ocd_w;
    logic [prpwm_pkg::WordW-1:0] cd_w;
    logic [prpwm_pkg::WordW-1:0] csd_w;
    int unsigned                 counted;
    int unsigned                 run_len;
    bit                          hold;

    // registers straight out of reset, all four words
    enqueue(prpwm_pkg::OP_READ, prpwm_pkg::ADDR_OUT_DIV, '0, 1'b0);
    enqueue(prpwm_pkg::OP_READ, prpwm_pkg::ADDR_DUTY, '1, 1'b0);
    enqueue(prpwm_pkg::OP_READ, prpwm_pkg::ADDR_SRC_DIV, '0, 1'b0);
    enqueue(prpwm_pkg::OP_READ, AddrUnused, '0, 1'b0);
    enqueue(prpwm_pkg::OP_TICK, prpwm_pkg::ADDR_OUT_DIV, '1, 1'b0);   // everything disabled
    enqueue(prpwm_pkg::OP_WRITE, prpwm_pkg::ADDR_OUT_DIV, '1, 1'b0);
    enqueue(prpwm_pkg::OP_READ, prpwm_pkg::ADDR_OUT_DIV, '0, 1'b0);
    enqueue(prpwm_pkg::OP_WRITE, prpwm_pkg::ADDR_SRC_DIV, '1, 1'b0);  // upper half dropped
    enqueue(prpwm_pkg::OP_READ, prpwm_pkg::ADDR_SRC_DIV, '0, 1'b0);
    enqueue(prpwm_pkg::OP_WRITE, AddrUnused, '1, 1'b0);               // stores nothing
    enqueue(prpwm_pkg::OP_READ, AddrUnused, '0, 1'b0);
    enqueue(OpUnknown, prpwm_pkg::ADDR_OUT_DIV, '1, 1'b0);            // no effect
    // lane 0 ocd 0 always on, lane 3 duty past period, smallest prescaler
    enqueue(prpwm_pkg::OP_WRITE, prpwm_pkg::ADDR_OUT_DIV, 32'h03020100, 1'b0);
    enqueue(prpwm_pkg::OP_WRITE, prpwm_pkg::ADDR_DUTY, 32'hff010002, 1'b0);
    enqueue(prpwm_pkg::OP_WRITE, prpwm_pkg::ADDR_SRC_DIV, '0, 1'b0);
    repeat (8) enqueue(prpwm_pkg::OP_TICK, prpwm_pkg::ADDR_DUTY, $urandom, 1'b0);
    enqueue(prpwm_pkg::OP_WRITE, prpwm_pkg::ADDR_DUTY, '0, 1'b0);     // write mid-count
    enqueue(prpwm_pkg::OP_WRITE, prpwm_pkg::ADDR_OUT_DIV, '0, 1'b0);  // back to all disabled

    // random programs, each followed by a run of ticks with reads mixed in
    counted = 0;
    hold = 1'b1;
    while (counted < RandomBeats) begin
      if ($urandom_range(0, 7) == 0) begin
        ocd_w = $urandom;
        enqueue(2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)), ocd_w, hold);
        if (pending_q[$].beat.op != OpUnknown) counted++;
      end else begin
        ocd_w = lane_fields(prpwm_pkg::OcdW, ($urandom_range(0, 3) == 0) ? 255 : 6);
        cd_w = lane_fields(prpwm_pkg::CdW, ($urandom_range(0, 3) == 0) ? 255 : 7);
        csd_w = lane_fields(prpwm_pkg::CsdW, ($urandom_range(0, 7) == 0) ? 15 : 2);
        // some lanes fully disabled
        for (int n = 0; n < prpwm_pkg::LanesMax; n++) begin
          if ($urandom_range(0, 4) == 0) begin
            ocd_w[prpwm_pkg::OcdW*n +: prpwm_pkg::OcdW] = '0;
            cd_w[prpwm_pkg::CdW*n +: prpwm_pkg::CdW] = '0;
            csd_w[prpwm_pkg::CsdW*n +: prpwm_pkg::CsdW] = '0;
          end
        end
        // junk in the unused upper half of the source-divider word
        csd_w[prpwm_pkg::WordW-1:prpwm_pkg::SrcWordW] = $urandom;
        enqueue(prpwm_pkg::OP_WRITE, prpwm_pkg::ADDR_OUT_DIV, ocd_w, hold);
        enqueue(prpwm_pkg::OP_WRITE, prpwm_pkg::ADDR_DUTY, cd_w, 1'b0);
        enqueue(prpwm_pkg::OP_WRITE, prpwm_pkg::ADDR_SRC_DIV, csd_w, 1'b0);
        counted += 3;
      end
      hold = ($urandom_range(0, 9) == 0);
      run_len = $urandom_range(10, 150);
      repeat (run_len) begin
        case ($urandom_range(0, 63))
          0: enqueue(OpUnknown, 2'($urandom_range(0, 3)), $urandom, 1'b0);
          1: begin
            enqueue(prpwm_pkg::OP_WRITE, 2'($urandom_range(0, 3)), $urandom, 1'b0);
            counted++;
          end
          2, 3, 4, 5: begin
            enqueue(prpwm_pkg::OP_READ, 2'($urandom_range(0, 3)), $urandom, 1'b0);
            counted++;
          end
          default: begin
            enqueue(prpwm_pkg::OP_TICK, 2'($urandom_range(0, 3)), $urandom, 1'b0);
            counted++;
          end
        endcase
      end
    end

    wait (rst_ni);
    while (pending_q.size() != 0 || expected_q.size() != 0) @(posedge clk_i);
    // catch any stray beat after the last expected one
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("packed_register_pwm_four_channel_top regression: pass");
    end else begin
      $display("packed_register_pwm_four_channel_top regression: fail");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/prpwm_pkg.sv
rtl/prpwm_regs.sv
rtl/prpwm_lane.sv
rtl/packed_register_pwm_four_channel_top.sv
bench/packed_register_pwm_four_channel_top_tb.sv
